// ===== rtl/core/stereo_biquad_eq_cascade_assert.svh =====
// Assertion macros shared by the equalizer RTL.
// Every property samples on aclk and is disabled while aresetn is low.
`ifndef STEREO_BIQUAD_EQ_CASCADE_ASSERT_SVH
`define STEREO_BIQUAD_EQ_CASCADE_ASSERT_SVH

`ifndef SYNTH

`define SBQ_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("sbq assertion failed");

`define SBQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbq assertion failed");

`define SBQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbq assertion failed");

`else

`define SBQ_ASSERT(lbl, expr)
`define SBQ_ASSERT_IMPL(lbl, ante, cons)
`define SBQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/sbq_pkg.sv =====
`default_nettype none

package sbq_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } sbq_state_t;

    typedef logic [2:0] sbq_phase_t;
    typedef logic [2:0] sbq_slot_t;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_COEF  = 1'b1;

    localparam int NUM_SLOTS = 5;

    localparam sbq_slot_t SLOT_B0 = 3'd0;
    localparam sbq_slot_t SLOT_B1 = 3'd1;
    localparam sbq_slot_t SLOT_B2 = 3'd2;
    localparam sbq_slot_t SLOT_A1 = 3'd3;
    localparam sbq_slot_t SLOT_A2 = 3'd4;

    // phases of one section
    localparam sbq_phase_t PH_FIRST     = 3'd0;
    localparam sbq_phase_t PH_RD_LAST   = 3'd4;
    localparam sbq_phase_t PH_MUL_FIRST = 3'd1;
    localparam sbq_phase_t PH_MUL_LAST  = 3'd5;
    localparam sbq_phase_t PH_ACC_FIRST = 3'd2;
    localparam sbq_phase_t PH_ACC_LAST  = 3'd6;
    localparam sbq_phase_t PH_LAST      = 3'd7;

    typedef struct packed {
        logic mul_en;
        logic sub;
        logic acc_load;
        logic acc_en;
    } sbq_mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbq_mac.sv =====
`default_nettype none

module sbq_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  wire                           aclk,
    input  wire sbq_pkg::sbq_mac_ctrl_t   ctrl,
    input  wire logic signed [COEF_BITS-1:0]   coef,
    input  wire logic signed [SAMPLE_BITS-1:0] operand,
    output logic signed [SAMPLE_BITS-1:0]      y
);

    localparam int PROD_W    = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W     = PROD_W + 3;
    localparam int COEF_FRAC = COEF_BITS - 4;
    localparam int SHIFT_W   = ACC_W - COEF_FRAC;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [SHIFT_W-1:0] SAT_MAX =
        SHIFT_W'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
    localparam logic signed [SHIFT_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_W-1:0]  prod_reg;
    logic                      sub_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [SHIFT_W-1:0] shifted;

    assign term = sub_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(coef) * PROD_W'(operand);
            sub_reg  <= ctrl.sub;
        end
        if (ctrl.acc_load) begin
            acc_reg <= term;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + term;
        end
    end

    // round half up, then clamp to the sample range
    always_comb begin
        rounded = acc_reg + HALF;
        shifted = rounded[ACC_W-1:COEF_FRAC];
        if (shifted > SAT_MAX) begin
            y = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_MIN) begin
            y = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            y = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stereo_biquad_eq_cascade.sv =====
// Stereo biquad cascade, NUM_BANDS direct-form-1 sections per channel on one shared MAC.
// A frame request is taken only in the idle state, once the previous result has moved into
// the output register; each section runs the eight-phase section sequence (five coefficient
// reads through one memory port, one multiplier).
// A coefficient write request is accepted in the idle state and gives no result.
// Reset (aresetn low, synchronous) clears per-entry valid bits: all bands pass through, history zero.
`default_nettype none
`include "stereo_biquad_eq_cascade_assert.svh"

module stereo_biquad_eq_cascade #(
    parameter int NUM_BANDS   = 4,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32,
    localparam int BAND_W     = (NUM_BANDS > 4) ? $clog2(NUM_BANDS) : 2
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_op,
    input  wire logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0] s_right_in,
    input  wire logic [BAND_W-1:0]        s_coef_band,
    input  wire logic [2:0]               s_coef_slot,
    input  wire logic signed [COEF_BITS-1:0]   s_coef_value,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);

    localparam int COEF_DEPTH = NUM_BANDS * sbq_pkg::NUM_SLOTS;
    localparam int CADDR_W    = $clog2(COEF_DEPTH);
    localparam int HDEPTH     = NUM_BANDS * 2;
    localparam int HADDR_W    = $clog2(HDEPTH);
    localparam int SW         = SAMPLE_BITS;
    localparam int ROW_W      = 4 * SW;
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 4);

    sbq_pkg::sbq_state_t state_reg, state_next;
    sbq_pkg::sbq_phase_t phase_reg, phase_next;
    logic [HADDR_W-1:0]  sec_reg, sec_next;
    logic signed [SW-1:0] l_reg, l_next, r_reg, r_next;
    logic                m_valid_reg, m_valid_next;
    logic signed [SW-1:0] m_left_reg, m_left_next, m_right_reg, m_right_next;

    // coefficient store
    logic signed [COEF_BITS-1:0] coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]       coef_vld_reg;
    logic signed [COEF_BITS-1:0] coef_rd_reg;
    logic                        coef_rd_vld_reg;
    sbq_pkg::sbq_slot_t          rd_slot_reg;

    // history store: one row per band and channel {y2, y1, x2, x1}
    logic [ROW_W-1:0]  hist_mem [HDEPTH];
    logic [HDEPTH-1:0] hist_vld_reg;
    logic [ROW_W-1:0]  hist_rd_reg;
    logic              hist_rd_vld_reg;

    logic               frame_acc, coef_acc, coef_ok, out_free, last_sec, cur_ch;
    logic               coef_we, coef_re, hist_re, hist_we;
    logic [CADDR_W-1:0] coef_wr_addr, coef_rd_addr, band_base;
    logic [ROW_W-1:0]   hist_row, hist_new;
    logic signed [SW-1:0] x_cur, h_x1, h_x2, h_y1, h_y2, mac_y, operand;
    logic signed [COEF_BITS-1:0] coef_eff;
    sbq_pkg::sbq_mac_ctrl_t mac_ctrl;

    assign frame_acc = s_valid && s_ready && (s_op == sbq_pkg::OP_FRAME);
    assign coef_acc  = s_valid && s_ready && (s_op == sbq_pkg::OP_COEF);
    assign coef_ok   = (32'(s_coef_band) < NUM_BANDS) && (32'(s_coef_slot) < sbq_pkg::NUM_SLOTS);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_sec  = (sec_reg == HADDR_W'(HDEPTH - 1));
    assign cur_ch    = sec_reg[0];
    assign x_cur     = cur_ch ? r_reg : l_reg;

    assign band_base    = CADDR_W'(sec_reg >> 1) * CADDR_W'(sbq_pkg::NUM_SLOTS);
    assign coef_rd_addr = band_base + CADDR_W'(phase_reg);
    assign coef_wr_addr = CADDR_W'(s_coef_band) * CADDR_W'(sbq_pkg::NUM_SLOTS)
                        + CADDR_W'(s_coef_slot);

    // unwritten entries read as their reset value
    assign coef_eff = coef_rd_vld_reg ? coef_rd_reg
                    : ((rd_slot_reg == sbq_pkg::SLOT_B0) ? COEF_ONE : '0);
    assign hist_row = hist_rd_vld_reg ? hist_rd_reg : '0;
    assign h_x1     = hist_row[SW-1:0];
    assign h_x2     = hist_row[2*SW-1:SW];
    assign h_y1     = hist_row[3*SW-1:2*SW];
    assign h_y2     = hist_row[4*SW-1:3*SW];
    assign hist_new = {h_y1, mac_y, h_x1, x_cur};

    always_comb begin
        case (rd_slot_reg)
            sbq_pkg::SLOT_B0: operand = x_cur;
            sbq_pkg::SLOT_B1: operand = h_x1;
            sbq_pkg::SLOT_B2: operand = h_x2;
            sbq_pkg::SLOT_A1: operand = h_y1;
            default:          operand = h_y2;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbq_pkg::ST_IDLE: begin
                if (frame_acc) begin
                    state_next = sbq_pkg::ST_RUN;
                end
            end
            sbq_pkg::ST_RUN: begin
                if (phase_reg == sbq_pkg::PH_LAST && last_sec) begin
                    state_next = sbq_pkg::ST_HOLD;
                end
            end
            sbq_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = sbq_pkg::ST_IDLE;
                end
            end
            default: state_next = sbq_pkg::ST_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        s_ready  = (state_reg == sbq_pkg::ST_IDLE);
        coef_we  = coef_acc && coef_ok;
        coef_re  = 1'b0;
        hist_re  = 1'b0;
        hist_we  = 1'b0;
        mac_ctrl = '0;
        case (state_reg)
            sbq_pkg::ST_RUN: begin
                coef_re         = (phase_reg <= sbq_pkg::PH_RD_LAST);
                hist_re         = (phase_reg == sbq_pkg::PH_FIRST);
                hist_we         = (phase_reg == sbq_pkg::PH_LAST);
                mac_ctrl.mul_en = (phase_reg >= sbq_pkg::PH_MUL_FIRST)
                               && (phase_reg <= sbq_pkg::PH_MUL_LAST);
                mac_ctrl.sub    = (rd_slot_reg == sbq_pkg::SLOT_A1)
                               || (rd_slot_reg == sbq_pkg::SLOT_A2);
                mac_ctrl.acc_load = (phase_reg == sbq_pkg::PH_ACC_FIRST);
                mac_ctrl.acc_en   = (phase_reg > sbq_pkg::PH_ACC_FIRST)
                                 && (phase_reg <= sbq_pkg::PH_ACC_LAST);
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        phase_next   = phase_reg;
        sec_next     = sec_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_left_next  = m_left_reg;
        m_right_next = m_right_reg;
        case (state_reg)
            sbq_pkg::ST_IDLE: begin
                if (frame_acc) begin
                    l_next     = s_left_in;
                    r_next     = s_right_in;
                    phase_next = sbq_pkg::PH_FIRST;
                    sec_next   = '0;
                end
            end
            sbq_pkg::ST_RUN: begin
                if (phase_reg == sbq_pkg::PH_LAST) begin
                    phase_next = sbq_pkg::PH_FIRST;
                    // section output feeds the next band of the same channel
                    if (cur_ch) begin
                        r_next = mac_y;
                    end else begin
                        l_next = mac_y;
                    end
                    if (!last_sec) begin
                        sec_next = sec_reg + HADDR_W'(1);
                    end
                end else begin
                    phase_next = phase_reg + sbq_pkg::sbq_phase_t'(1);
                end
            end
            sbq_pkg::ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_left_next  = l_reg;
                    m_right_next = r_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sbq_pkg::ST_IDLE;
            phase_reg    <= sbq_pkg::PH_FIRST;
            sec_reg      <= '0;
            m_valid_reg  <= 1'b0;
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            sec_reg     <= sec_next;
            m_valid_reg <= m_valid_next;
            if (coef_we) begin
                coef_vld_reg[coef_wr_addr] <= 1'b1;
            end
            if (hist_we) begin
                hist_vld_reg[sec_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        l_reg       <= l_next;
        r_reg       <= r_next;
        m_left_reg  <= m_left_next;
        m_right_reg <= m_right_next;
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_wr_addr] <= s_coef_value;
        end
        if (coef_re) begin
            coef_rd_reg     <= coef_mem[coef_rd_addr];
            coef_rd_vld_reg <= coef_vld_reg[coef_rd_addr];
            rd_slot_reg     <= sbq_pkg::sbq_slot_t'(phase_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[sec_reg] <= hist_new;
        end
        if (hist_re) begin
            hist_rd_reg     <= hist_mem[sec_reg];
            hist_rd_vld_reg <= hist_vld_reg[sec_reg];
        end
    end

    sbq_mac #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .coef   (coef_eff),
        .operand(operand),
        .y      (mac_y)
    );

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

    `SBQ_ASSERT_NEXT(a_frame_start, frame_acc, (state_reg == sbq_pkg::ST_RUN) && (sec_reg == '0) && (phase_reg == sbq_pkg::PH_FIRST))
    `SBQ_ASSERT_NEXT(a_coef_write_idle, coef_acc, state_reg == sbq_pkg::ST_IDLE)
    `SBQ_ASSERT_NEXT(a_hold_delivers, (state_reg == sbq_pkg::ST_HOLD) && out_free, m_valid_reg && (state_reg == sbq_pkg::ST_IDLE))
    `SBQ_ASSERT_IMPL(a_result_only_from_hold, m_valid_reg && !$past(m_valid_reg), $past(state_reg) == sbq_pkg::ST_HOLD)

endmodule

`default_nettype wire
